// ----- rtl/yerp_pkg.sv -----
// shared constants for the yuv420 edge-replicate frame padder
package yerp_pkg;

  // sample and position widths
  localparam int SAMPLE_W = 8;
  localparam int POS_W    = 12;
  localparam int PLANE_W  = 2;

  // configuration port
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  // width used for clamped plane dimensions (holds up to 8192 + pad)
  localparam int DIM_W = 14;

  // line store depth default, horizontal pad limit and row limit
  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_HPAD      = 63;
  localparam int ROW_LIMIT     = 4096;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_HEIGHT = 2'd3;

  // register reset values
  localparam logic [CFG_W-1:0] RST_INPUT_WIDTH  = 13'd1920;
  localparam logic [CFG_W-1:0] RST_INPUT_HEIGHT = 13'd1080;
  localparam logic [CFG_W-1:0] RST_ARRAY_WIDTH  = 13'd1920;
  localparam logic [CFG_W-1:0] RST_ARRAY_HEIGHT = 13'd1088;

  // input opcodes
  localparam logic OP_RAW  = 1'b0;
  localparam logic OP_FILL = 1'b1;

  // plane codes
  localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

endpackage

// ----- rtl/yerp_line_store.sv -----
// padded row line store: one write port, one registered read port
module yerp_line_store #(
  parameter int  DEPTH = yerp_pkg::MAX_WIDTH_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [yerp_pkg::SAMPLE_W-1:0] wdata,
  input  logic [AW-1:0]                 raddr,
  output logic [yerp_pkg::SAMPLE_W-1:0] rdata
);

  logic [yerp_pkg::SAMPLE_W-1:0] mem [DEPTH];

  // write, and read with forwarding of a same-cycle write to the same entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/yuv420_edge_replicate_pad_unit.sv -----
// top level of the yuv420 edge-replicate frame padder
//
// Takes a planar 4:2:0 byte stream (luma, then first and second chroma at half
// size) and emits each plane padded to the array size, one sample per beat.
// A raw pixel inside a row and a fill tick each give one beat; fill ticks that
// arrive when no vertical fill is pending give nothing. The pixel that ends a
// row gives (padded width - column) beats, at most MAX_HPAD + 1, one per cycle
// while the output is not stalled, and the input is stalled until its last
// beat leaves the burst unit; that unit writes the replicated samples into a
// single-port-write line store of MAX_WIDTH bytes, which fill ticks read back
// in the cycle after they are accepted. With the output never stalled the
// block sustains one beat per cycle. The line store needs no clearing pass after
// reset; fill ticks only read entries already written by the last input row.
module yuv420_edge_replicate_pad_unit #(
  parameter int MAX_WIDTH = yerp_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration writes
  input  logic                           cfg_write,
  input  logic [yerp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [yerp_pkg::CFG_W-1:0]     cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           opcode,
  input  logic [yerp_pkg::SAMPLE_W-1:0]  pixel,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [yerp_pkg::SAMPLE_W-1:0]  sample,
  output logic [yerp_pkg::PLANE_W-1:0]   plane,
  output logic [yerp_pkg::POS_W-1:0]     column,
  output logic [yerp_pkg::POS_W-1:0]     line,
  output logic                           last,
  output logic                           frame_end,
  output logic                           error
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int DW    = yerp_pkg::DIM_W;
  localparam int POS_W = yerp_pkg::POS_W;
  localparam int HW    = POS_W + 1;
  localparam int CW    = yerp_pkg::CFG_W;

  localparam logic [DW-1:0] MAXW     = DW'(MAX_WIDTH);
  localparam logic [DW-1:0] HPAD     = DW'(yerp_pkg::MAX_HPAD);
  localparam logic [HW-1:0] ROW_LIM  = HW'(yerp_pkg::ROW_LIMIT);

  // one pending output job: a single beat or a row-end replication burst
  typedef struct packed {
    logic [yerp_pkg::SAMPLE_W-1:0] sample;
    logic [yerp_pkg::PLANE_W-1:0]  plane;
    logic [AW-1:0]                 col;
    logic [AW-1:0]                 col_end;
    logic [POS_W-1:0]              row;
    logic                          fend;
    logic                          err;
    logic                          wr;
  } job_t;

  // configuration registers
  logic [CW-1:0] src_width, src_height, arr_width, arr_height;

  // stream position state
  logic [yerp_pkg::PLANE_W-1:0] plane_index, plane_index_next;
  logic [AW-1:0]                col_count, col_count_next;
  logic [POS_W-1:0]             row_count, row_count_next;
  logic                         filling, filling_next;

  // burst unit
  job_t job, job_in;
  logic j_valid, j_rd, job_load;
  logic o_free, j_beat, j_last, j_done, acc;
  logic [yerp_pkg::SAMPLE_W-1:0] store_rdata, s_eff;

  // plane dimensions
  logic          chroma;
  logic [CW-1:0] w_sh, h_sh, aw_sh, ah_sh;
  logic [DW-1:0] in_w, top_sum, top_w, aw_ext, pad_w;
  logic [HW-1:0] in_h, pad_h;
  logic [DW-1:0] col_inc;
  logic [HW-1:0] row_inc;
  logic [yerp_pkg::PLANE_W-1:0] plane_adv;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= yerp_pkg::RST_INPUT_WIDTH;
      src_height <= yerp_pkg::RST_INPUT_HEIGHT;
      arr_width  <= yerp_pkg::RST_ARRAY_WIDTH;
      arr_height <= yerp_pkg::RST_ARRAY_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        yerp_pkg::CFG_INPUT_WIDTH:  src_width  <= cfg_data;
        yerp_pkg::CFG_INPUT_HEIGHT: src_height <= cfg_data;
        yerp_pkg::CFG_ARRAY_WIDTH:  arr_width  <= cfg_data;
        yerp_pkg::CFG_ARRAY_HEIGHT: arr_height <= cfg_data;
      endcase
    end
  end

  // clamped sizes of the current plane
  always_comb begin
    chroma = (plane_index != yerp_pkg::PLANE_Y);
    w_sh   = chroma ? (src_width >> 1)  : src_width;
    h_sh   = chroma ? (src_height >> 1) : src_height;
    aw_sh  = chroma ? (arr_width >> 1)  : arr_width;
    ah_sh  = chroma ? (arr_height >> 1) : arr_height;

    if (w_sh == '0) begin
      in_w = DW'(1);
    end else if (DW'(w_sh) > MAXW) begin
      in_w = MAXW;
    end else begin
      in_w = DW'(w_sh);
    end
    top_sum = in_w + HPAD;
    top_w   = (top_sum > MAXW) ? MAXW : top_sum;
    aw_ext  = DW'(aw_sh);
    if (aw_ext < in_w) begin
      pad_w = in_w;
    end else if (aw_ext > top_w) begin
      pad_w = top_w;
    end else begin
      pad_w = aw_ext;
    end

    if (h_sh == '0) begin
      in_h = HW'(1);
    end else if (HW'(h_sh) > ROW_LIM) begin
      in_h = ROW_LIM;
    end else begin
      in_h = HW'(h_sh);
    end
    if (HW'(ah_sh) < in_h) begin
      pad_h = in_h;
    end else if (HW'(ah_sh) > ROW_LIM) begin
      pad_h = ROW_LIM;
    end else begin
      pad_h = HW'(ah_sh);
    end
  end

  // handshake between input, burst unit and output register
  assign o_free   = !out_valid || !out_stall;
  assign j_beat   = j_valid && o_free;
  assign j_last   = (job.col == job.col_end);
  assign j_done   = j_beat && j_last;
  assign in_stall = rst || (j_valid && !j_done);
  assign acc      = in_valid && !in_stall;
  assign s_eff    = j_rd ? store_rdata : job.sample;

  // next stream position and the job an accepted item creates
  always_comb begin
    col_count_next   = col_count;
    row_count_next   = row_count;
    plane_index_next = plane_index;
    filling_next     = filling;
    job_load         = 1'b0;
    col_inc          = DW'(col_count) + DW'(1);
    row_inc          = HW'(row_count) + HW'(1);
    plane_adv        = (plane_index == yerp_pkg::PLANE_V) ? yerp_pkg::PLANE_Y
                                                         : plane_index + 2'd1;
    job_in.sample    = pixel;
    job_in.plane     = plane_index;
    job_in.col       = col_count;
    job_in.col_end   = col_count;
    job_in.row       = row_count;
    job_in.fend      = 1'b0;
    job_in.err       = 1'b0;
    job_in.wr        = 1'b0;

    if (acc) begin
      if (opcode == yerp_pkg::OP_FILL) begin
        // fill tick replays the stored row; ignored outside vertical fill
        if (filling) begin
          job_load = 1'b1;
          if (col_inc >= pad_w) begin
            col_count_next = '0;
            row_count_next = row_inc[POS_W-1:0];
            if (row_inc >= pad_h) begin
              plane_index_next = plane_adv;
              row_count_next   = '0;
              filling_next     = 1'b0;
              job_in.fend      = (plane_index == yerp_pkg::PLANE_V);
            end
          end else begin
            col_count_next = AW'(col_inc);
          end
        end
      end else if (filling) begin
        // raw pixel during vertical fill is dropped and flagged
        job_load      = 1'b1;
        job_in.err    = 1'b1;
        job_in.sample = '0;
      end else begin
        job_load  = 1'b1;
        job_in.wr = 1'b1;
        if (col_inc < in_w) begin
          col_count_next = AW'(col_inc);
        end else begin
          // row end: replicate out to the padded width
          if (col_inc < pad_w) begin
            job_in.col_end = AW'(pad_w - DW'(1));
          end
          col_count_next = '0;
          row_count_next = row_inc[POS_W-1:0];
          if (row_inc >= in_h) begin
            if (row_inc >= pad_h) begin
              plane_index_next = plane_adv;
              row_count_next   = '0;
              job_in.fend      = (plane_index == yerp_pkg::PLANE_V);
            end else begin
              filling_next = 1'b1;
            end
          end
        end
      end
    end
  end

  // stream position registers
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_index <= yerp_pkg::PLANE_Y;
      col_count   <= '0;
      row_count   <= '0;
      filling     <= 1'b0;
    end else begin
      plane_index <= plane_index_next;
      col_count   <= col_count_next;
      row_count   <= row_count_next;
      filling     <= filling_next;
    end
  end

  // burst unit control
  always_ff @(posedge clk) begin
    if (rst) begin
      j_valid <= 1'b0;
      j_rd    <= 1'b0;
    end else if (job_load) begin
      j_valid <= 1'b1;
      j_rd    <= (opcode == yerp_pkg::OP_FILL);
    end else begin
      if (j_done) begin
        j_valid <= 1'b0;
      end
      j_rd <= 1'b0;
    end
  end

  // burst unit payload: step the column, capture read data once it lands
  always_ff @(posedge clk) begin
    if (job_load) begin
      job <= job_in;
    end else begin
      job.sample <= s_eff;
      if (j_beat && !j_last) begin
        job.col <= job.col + AW'(1);
      end
    end
  end

  yerp_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (j_beat && job.wr),
    .waddr (job.col),
    .wdata (job.sample),
    .raddr (col_count),
    .rdata (store_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (j_beat) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (j_beat) begin
      sample    <= s_eff;
      plane     <= job.plane;
      column    <= POS_W'(job.col);
      line      <= job.row;
      last      <= j_last;
      frame_end <= job.fend && j_last;
      error     <= job.err;
    end
  end

endmodule

// ----- rtl/yerp_checker.sv -----
// port-level checks for the yuv420 edge-replicate frame padder
module yerp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [yerp_pkg::SAMPLE_W-1:0]  sample,
  input logic [yerp_pkg::PLANE_W-1:0]   plane,
  input logic [yerp_pkg::POS_W-1:0]     column,
  input logic [yerp_pkg::POS_W-1:0]     line,
  input logic                           last,
  input logic                           frame_end,
  input logic                           error
);

  // no beat is left over after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // a stalled beat holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample) && $stable(column)
      && $stable(line) && $stable(last))
    else $error("stalled beat changed");

  // a burst continues on the next cycle at the next column of the same row
  a_burst_steps: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid
      && (column == yerp_pkg::POS_W'($past(column) + 12'd1))
      && (line == $past(line)) && (plane == $past(plane)))
    else $error("replication burst broke");

  // frame end only on the final beat of the second chroma plane
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> last && !error && (plane == yerp_pkg::PLANE_V))
    else $error("misplaced frame end");

  // a dropped pixel gives a single zero beat
  a_error_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> last && (sample == '0))
    else $error("malformed error beat");

endmodule

bind yuv420_edge_replicate_pad_unit yerp_checker u_yerp_checker (.*);

// ----- tb/testbench.sv -----
// self-checking testbench for the yuv420 edge-replicate frame padder
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import yerp_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [PLANE_W-1:0]  plane;
    logic [POS_W-1:0]    column;
    logic [POS_W-1:0]    line;
    logic                last;
    logic                frame_end;
    logic                error;
  } pad_beat_t;

  typedef struct packed {
    logic                op;
    logic [SAMPLE_W-1:0] px;
  } pad_item_t;

  // block ports
  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                opcode = OP_RAW;
  logic [SAMPLE_W-1:0] pixel = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SAMPLE_W-1:0] sample;
  logic [PLANE_W-1:0]  plane;
  logic [POS_W-1:0]    column;
  logic [POS_W-1:0]    line;
  logic                last;
  logic                frame_end;
  logic                error;

  yuv420_edge_replicate_pad_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .pixel     (pixel),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample),
    .plane     (plane),
    .column    (column),
    .line      (line),
    .last      (last),
    .frame_end (frame_end),
    .error     (error)
  );

  // register copies, reset values until written
  int cfg_in_w = int'(RST_INPUT_WIDTH);
  int cfg_in_h = int'(RST_INPUT_HEIGHT);
  int cfg_arr_w = int'(RST_ARRAY_WIDTH);
  int cfg_arr_h = int'(RST_ARRAY_HEIGHT);

  // padder state as predicted from accepted beats
  logic [PLANE_W-1:0]  cur_plane = PLANE_Y;
  int                  col_cnt = 0;
  int                  row_cnt = 0;
  bit                  filling = 1'b0;
  logic [SAMPLE_W-1:0] row_copy [0:MAX_WIDTH_DEF-1];

  // stream position the stimulus is building from
  logic [PLANE_W-1:0] gen_plane = PLANE_Y;
  int                 gen_col = 0;
  int                 gen_row = 0;
  bit                 gen_fill = 1'b0;

  pad_item_t pending_items [$];
  pad_beat_t expected_beats [$];
  int  items_queued = 0;
  int  items_accepted = 0;
  int  useful_items = 0;
  int  bad_beats = 0;
  bit  in_beat = 1'b0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  send_busy = 25;
  int  recv_busy = 25;
  bit  hold_request = 1'b0;
  bit  hold_off = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int bound(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rnd_px();
    return SAMPLE_W'($urandom_range(0, 255));
  endfunction

  // padded and unpadded size of one plane under the current registers
  function automatic void plane_dims(input logic [PLANE_W-1:0] p, output int in_w,
                                     output int in_h, output int pad_w, output int pad_h);
    int sh, top;
    sh = (p == PLANE_Y) ? 0 : 1;
    in_w = bound(cfg_in_w >> sh, 1, MAX_WIDTH_DEF);
    in_h = bound(cfg_in_h >> sh, 1, ROW_LIMIT);
    top = in_w + MAX_HPAD;
    if (top > MAX_WIDTH_DEF) top = MAX_WIDTH_DEF;
    pad_w = bound(cfg_arr_w >> sh, in_w, top);
    pad_h = bound(cfg_arr_h >> sh, in_h, ROW_LIMIT);
  endfunction

  function automatic int busy_pick();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 25;
      default: return 60;
    endcase
  endfunction

  // mostly short idle runs, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_beat(input logic [SAMPLE_W-1:0] s, input int col, input int row,
                           input logic lst, input logic fend, input logic err);
    pad_beat_t b;
    b.sample = s;
    b.plane = cur_plane;
    b.column = col[POS_W-1:0];
    b.line = row[POS_W-1:0];
    b.last = lst;
    b.frame_end = fend;
    b.error = err;
    expected_beats.push_back(b);
  endtask

  task automatic advance_plane();
    cur_plane = (cur_plane == PLANE_V) ? PLANE_Y : cur_plane + 2'd1;
    col_cnt = 0;
    row_cnt = 0;
    filling = 1'b0;
  endtask

  // expected output beats for one accepted input beat
  task automatic pad_predict(input logic op, input logic [SAMPLE_W-1:0] px);
    int  in_w, in_h, pad_w, pad_h, col, row, stop;
    logic fend, done;
    plane_dims(cur_plane, in_w, in_h, pad_w, pad_h);
    col = col_cnt;
    row = row_cnt;
    fend = 1'b0;
    done = 1'b0;
    if (op == OP_FILL) begin
      // fill tick replays the stored row, ignored outside vertical fill
      if (!filling) return;
      col_cnt = col + 1;
      if (col_cnt >= pad_w) begin
        col_cnt = 0;
        row_cnt = row + 1;
        if (row_cnt >= pad_h) begin
          done = 1'b1;
          fend = (cur_plane == PLANE_V);
        end
      end
      push_beat(row_copy[col], col, row, 1'b1, fend, 1'b0);
      if (done) advance_plane();
    end else if (filling) begin
      // raw pixel during fill is dropped and flagged
      push_beat('0, col, row, 1'b1, 1'b0, 1'b1);
    end else begin
      row_copy[col] = px;
      col_cnt = col + 1;
      if (col_cnt < in_w) begin
        push_beat(px, col, row, 1'b1, 1'b0, 1'b0);
      end else begin
        // row end: replicate out to the padded width
        stop = (pad_w > col + 1) ? pad_w : col + 1;
        col_cnt = 0;
        row_cnt = row + 1;
        if (row_cnt >= in_h) begin
          if (row_cnt >= pad_h) begin
            done = 1'b1;
            fend = (cur_plane == PLANE_V);
          end else begin
            filling = 1'b1;
          end
        end
        for (int c = col; c < stop; c++) begin
          row_copy[c] = px;
          push_beat(px, c, row, c == stop - 1, fend && (c == stop - 1), 1'b0);
        end
        if (done) advance_plane();
      end
    end
  endtask

  task automatic push_item(input logic op, input logic [SAMPLE_W-1:0] px,
                           input bit counts = 1'b1);
    pad_item_t it;
    it.op = op;
    it.px = px;
    pending_items.push_back(it);
    items_queued++;
    if (counts) useful_items++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_INPUT_WIDTH:  cfg_in_w = val & 'h1FFF;
      CFG_INPUT_HEIGHT: cfg_in_h = val & 'h1FFF;
      CFG_ARRAY_WIDTH:  cfg_arr_w = val & 'h1FFF;
      default:          cfg_arr_h = val & 'h1FFF;
    endcase
  endtask

  task automatic write_frame_size(input int w, input int h, input int aw, input int ah);
    write_reg(CFG_INPUT_WIDTH, w);
    write_reg(CFG_INPUT_HEIGHT, h);
    write_reg(CFG_ARRAY_WIDTH, aw);
    write_reg(CFG_ARRAY_HEIGHT, ah);
  endtask

  // sender pauses until every expected beat is back, then picks up the block position
  task automatic wait_idle(input int settle);
    while (items_accepted != items_queued || expected_beats.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
    gen_plane = cur_plane;
    gen_col = col_cnt;
    gen_row = row_cnt;
    gen_fill = filling;
  endtask

  // queue the rest of the current plane: raw rows, then fill ticks
  task automatic run_plane(input bit noisy);
    int in_w, in_h, pad_w, pad_h;
    plane_dims(gen_plane, in_w, in_h, pad_w, pad_h);
    if (!gen_fill) begin
      do begin
        do begin
          if (noisy && $urandom_range(0, 99) < 4)
            push_item(OP_FILL, rnd_px(), 1'b0);
          push_item(OP_RAW, rnd_px());
          gen_col++;
        end while (gen_col < in_w);
        gen_col = 0;
        gen_row++;
      end while (gen_row < in_h);
      gen_fill = (gen_row < pad_h);
    end
    if (gen_fill) begin
      do begin
        if (noisy && $urandom_range(0, 99) < 3)
          push_item(OP_RAW, rnd_px());
        push_item(OP_FILL, rnd_px());
        gen_col++;
        if (gen_col >= pad_w) begin
          gen_col = 0;
          gen_row++;
        end
      end while (!(gen_col == 0 && gen_row >= pad_h));
    end
    gen_plane = (gen_plane == PLANE_V) ? PLANE_Y : gen_plane + 2'd1;
    gen_col = 0;
    gen_row = 0;
    gen_fill = 1'b0;
  endtask

  // input driver: one beat per handshake, random gaps between beats
  always @(negedge clk) begin : feed
    pad_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat) begin
      if ($urandom_range(0, 63) == 0) send_busy = busy_pick();
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        nxt = pending_items.pop_front();
        in_valid <= 1'b1;
        opcode <= nxt.op;
        pixel <= nxt.px;
        if ($urandom_range(0, 99) < send_busy) gap_left = idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall: random runs plus the long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) recv_busy = busy_pick();
      if (stall_left == 0 && $urandom_range(0, 99) < recv_busy) stall_left = idle_len();
      out_stall <= hold_off || (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // long receiver hold-off while the sender keeps offering beats
  initial begin
    wait (hold_request);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  // accepted input beats feed the predictor, output beats are checked in order
  always @(posedge clk) begin : beat_check
    pad_beat_t got, want;
    if (rst) begin
      in_beat = 1'b0;
    end else begin
      in_beat = in_valid && !in_stall;
      if (in_beat) begin
        items_accepted++;
        pad_predict(opcode, pixel);
      end
      if (out_valid && !out_stall) begin
        got = {sample, plane, column, line, last, frame_end, error};
        if (expected_beats.size() == 0) begin
          if (bad_beats < 10)
            $display("unexpected beat: sample %0d plane %0d col %0d line %0d last %0b fend %0b err %0b",
                     got.sample, got.plane, got.column, got.line, got.last, got.frame_end,
                     got.error);
          bad_beats++;
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            if (bad_beats < 10) begin
              $display("mismatch: expected sample %0d plane %0d col %0d line %0d last %0b fend %0b err %0b",
                       want.sample, want.plane, want.column, want.line, want.last,
                       want.frame_end, want.error);
              $display("          got      sample %0d plane %0d col %0d line %0d last %0b fend %0b err %0b",
                       got.sample, got.plane, got.column, got.line, got.last, got.frame_end,
                       got.error);
            end
            bad_beats++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int goal, w, h, aw, ah;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // tiny frame: ignored tick, extreme pixels, row replication, dropped pixel,
    // vertical fill, chroma without vertical pad, frame end
    write_frame_size(2, 2, 5, 3);
    push_item(OP_FILL, 8'hFF, 1'b0);
    push_item(OP_RAW, 8'h00);
    push_item(OP_RAW, 8'hFF);
    push_item(OP_RAW, 8'h5A);
    push_item(OP_RAW, 8'hA5);
    push_item(OP_RAW, 8'h3C);
    repeat (5) push_item(OP_FILL, rnd_px());
    push_item(OP_RAW, 8'hFF);
    push_item(OP_RAW, 8'h00);
    wait_idle(16);

    // registers changed mid-plane: row and plane already past their new end
    write_frame_size(4096, 8191, 6, 8191);
    repeat (3) push_item(OP_RAW, rnd_px());
    wait_idle(16);
    write_reg(CFG_INPUT_WIDTH, 2);
    write_reg(CFG_INPUT_HEIGHT, 1);
    push_item(OP_RAW, rnd_px());
    repeat (3) push_item(OP_FILL, rnd_px());
    wait_idle(16);
    write_reg(CFG_ARRAY_HEIGHT, 2);
    wait_idle(16);
    do run_plane(1'b0); while (gen_plane != PLANE_Y);

    // random frames, mostly small
    wait_idle(16);
    goal = useful_items + 430;
    for (int f = 0; useful_items < goal; f++) begin
      wait_idle(16);
      if (f == 0) begin
        w = 12;
        h = 6;
        aw = 20;
        ah = 8;
      end else begin
        w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 14);
        h = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
        case ($urandom_range(0, 5))
          0: aw = w;
          1, 2: aw = w + $urandom_range(1, 8);
          3: aw = $urandom_range(0, w);
          4: aw = w + $urandom_range(60, 80);
          default: aw = w + $urandom_range(1, 3);
        endcase
        case ($urandom_range(0, 3))
          0: ah = h;
          1, 2: ah = h + $urandom_range(1, 3);
          default: ah = $urandom_range(0, h);
        endcase
      end
      write_frame_size(w, h, aw, ah);
      do run_plane(1'b1); while (gen_plane != PLANE_Y);
      if (f == 0) hold_request = 1'b1;
    end

    wait_idle(100);
    if (bad_beats == 0 && expected_beats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/yerp_pkg.sv
rtl/yerp_line_store.sv
rtl/yuv420_edge_replicate_pad_unit.sv
rtl/yerp_checker.sv
tb/testbench.sv
